@@ src/ase_pkg.sv @@
package ase_pkg;

  localparam int unsigned FRAC_BITS = 38;
  localparam int unsigned MAX_TERMS = 1024;
  localparam int unsigned AW        = $clog2(MAX_TERMS);
  localparam int unsigned TW        = 40;           // term, sum and multiplier a operand
  localparam int unsigned HW        = TW / 2;       // multiplier b half width
  localparam int unsigned CNT_W     = 11;
  localparam int unsigned DIV_STEPS = 2 * FRAC_BITS;
  localparam logic [CNT_W-1:0] TERM_COUNT_RST = 11'd1000;
  localparam logic [31:0]      HALF_PI_Q30    = 32'd1686629713;

  typedef enum logic [4:0] {
    ST_INIT, ST_RLOAD, ST_RDIV, ST_RWRITE,
    ST_IDLE, ST_SQUARE, ST_DLOAD, ST_DIV, ST_DRAIN,
    ST_S0, ST_S1, ST_S2, ST_S3, ST_SACC,
    ST_F0, ST_F1, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MB_R, MB_RATIO, MB_ROOT
  } mul_b_e;

  typedef struct packed {
    logic          load_x;
    logic          square;
    logic          load_div_main;
    logic          ratio_init;
    logic          load_div_ratio;
    logic          ratio_next;
    logic          div_step;
    logic          quo_en;
    logic          pair_hi;
    logic          pair_lo;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic          mul_lo;
    logic          mul_hi;
    logic          mul_a_sum;
    mul_b_e        mul_b;
    logic          mul_to_res;
    logic          sum_add;
    logic          out_load;
  } cmd_t;

endpackage

@@ src/ase_datapath.sv @@
module ase_datapath import ase_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [31:0] x_i,
  output logic [31:0] angle_o
);

  // argument
  logic        neg_q;
  logic [31:0] mag_q;
  logic [63:0] x2_q;

  // shared restoring divider
  logic [63:0] rem_q, rem_d;
  logic [62:0] den_q;
  logic [FRAC_BITS-1:0] quo_q;
  logic [64:0] rem2;
  logic        qbit;

  // square root fed two quotient bits at a time
  logic        hib_q, lob_q, pend_q;
  logic [41:0] srem_q, srem_sh, trial;
  logic [FRAC_BITS-1:0] root_q;

  // ratio table generation
  logic [21:0] rnum_q;
  logic [22:0] rden_q;
  logic [CNT_W-1:0] rk_q;
  logic [FRAC_BITS-1:0] ratio_mem [MAX_TERMS];
  logic [FRAC_BITS-1:0] ratio_q;

  // series
  logic [TW-1:0] term_q, sum_q;
  logic [TW-1:0] mul_a, mul_b40;
  logic [HW-1:0] mul_bh;
  logic [TW+HW-1:0] prod;
  logic [TW+HW-1:0] acc_q;
  logic [2*TW:0] full;
  logic [33:0] res_q;
  logic [31:0] sat;
  logic [31:0] angle_q;

  assign rem2 = {rem_q, 1'b0};
  assign qbit = rem2 >= {2'b00, den_q};
  assign rem_d = qbit ? 64'(rem2 - {2'b00, den_q}) : rem2[63:0];

  assign srem_sh = {srem_q[39:0], hib_q, lob_q};
  assign trial   = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_x) begin
      neg_q <= x_i[31];
      mag_q <= x_i[31] ? 32'(-x_i) : x_i;
    end
    if (cmd_i.square) begin
      x2_q <= 64'(mag_q) * 64'(mag_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_div_main) begin
      rem_q  <= x2_q;
      den_q  <= 63'(x2_q + 64'h1_0000_0000);
      quo_q  <= '0;
      srem_q <= '0;
      root_q <= '0;
      term_q <= TW'(1) << FRAC_BITS;
      sum_q  <= TW'(1) << FRAC_BITS;
    end else begin
      if (cmd_i.load_div_ratio) begin
        rem_q <= 64'(rnum_q);
        den_q <= 63'(rden_q);
        quo_q <= '0;
      end else if (cmd_i.div_step) begin
        rem_q <= rem_d;
        if (cmd_i.quo_en) quo_q <= {quo_q[FRAC_BITS-2:0], qbit};
      end
      if (pend_q) begin
        if (srem_sh >= trial) begin
          srem_q <= srem_sh - trial;
          root_q <= {root_q[FRAC_BITS-2:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          root_q <= {root_q[FRAC_BITS-2:0], 1'b0};
        end
      end
      if (cmd_i.mul_hi && !cmd_i.mul_to_res) term_q <= full[FRAC_BITS +: TW];
      if (cmd_i.sum_add) sum_q <= sum_q + term_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.div_step && cmd_i.pair_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step && cmd_i.pair_hi) hib_q <= qbit;
    if (cmd_i.div_step && cmd_i.pair_lo) lob_q <= qbit;
  end

  // numerator (2k-1)^2 and denominator 2k(2k+1) stepped along k
  always_ff @(posedge clk_i) begin
    if (cmd_i.ratio_init) begin
      rnum_q <= 22'd1;
      rden_q <= 23'd6;
      rk_q   <= CNT_W'(1);
    end else if (cmd_i.ratio_next) begin
      rnum_q <= rnum_q + {8'd0, rk_q, 3'b000};
      rden_q <= rden_q + {9'd0, rk_q, 3'b000} + 23'd6;
      rk_q   <= rk_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) ratio_mem[cmd_i.mem_addr] <= quo_q;
    if (cmd_i.mem_re) ratio_q <= ratio_mem[cmd_i.mem_addr];
  end

  // 40 x 20 multiplier, two passes per product
  always_comb begin
    mul_a = cmd_i.mul_a_sum ? sum_q : term_q;
    unique case (cmd_i.mul_b)
      MB_R:     mul_b40 = TW'(quo_q);
      MB_RATIO: mul_b40 = TW'(ratio_q);
      MB_ROOT:  mul_b40 = TW'(root_q);
      default:  mul_b40 = '0;
    endcase
    mul_bh = cmd_i.mul_hi ? mul_b40[TW-1:HW] : mul_b40[HW-1:0];
    prod   = (TW+HW)'(mul_a) * (TW+HW)'(mul_bh);
    full   = (2*TW+1)'(acc_q) + ((2*TW+1)'(prod) << HW);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_lo) acc_q <= prod;
    if (cmd_i.mul_hi && cmd_i.mul_to_res) res_q <= full[FRAC_BITS+8 +: 34];
  end

  assign sat = (res_q > 34'(HALF_PI_Q30)) ? HALF_PI_Q30 : res_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) angle_q <= neg_q ? 32'(-sat) : sat;
  end

  assign angle_o = angle_q;

endmodule

@@ src/ase_ctrl.sv @@
module ase_ctrl import ase_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d;
  logic [6:0]       cnt_q, cnt_d;
  logic [CNT_W-1:0] k_q, k_d, n_q, n_d, tc_q;
  logic             out_vld_q;
  logic             slot_free;
  logic [CNT_W-1:0] k_m1;

  assign slot_free = !out_vld_q || out_ready_i;
  assign k_m1      = k_q - CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      cnt_q     <= '0;
      k_q       <= '0;
      n_q       <= '0;
      tc_q      <= TERM_COUNT_RST;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      n_q     <= n_d;
      if (cfg_we_i) tc_q <= cfg_wdata_i;
      if (cmd_o.out_load) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    n_d     = n_q;
    unique case (state_q)
      ST_INIT: begin
        k_d     = CNT_W'(1);
        state_d = ST_RLOAD;
      end
      ST_RLOAD: begin
        cnt_d   = '0;
        state_d = ST_RDIV;
      end
      ST_RDIV: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(FRAC_BITS - 1)) state_d = ST_RWRITE;
      end
      ST_RWRITE: begin
        k_d = k_q + CNT_W'(1);
        if (k_q == CNT_W'(MAX_TERMS)) state_d = ST_IDLE;
        else state_d = ST_RLOAD;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          n_d     = (tc_q > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : tc_q;
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: state_d = ST_DLOAD;
      ST_DLOAD: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(DIV_STEPS - 1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        k_d     = CNT_W'(1);
        state_d = (n_q == '0) ? ST_F0 : ST_S0;
      end
      ST_S0: state_d = ST_S1;
      ST_S1: state_d = ST_S2;
      ST_S2: state_d = ST_S3;
      ST_S3: begin
        if (k_q == n_q) begin
          state_d = ST_SACC;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = ST_S0;
        end
      end
      ST_SACC: state_d = ST_F0;
      ST_F0:   state_d = ST_F1;
      ST_F1:   state_d = ST_OUT;
      ST_OUT:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_b    = MB_R;
    cmd_o.mem_addr = k_m1[AW-1:0];
    unique case (state_q)
      ST_INIT:   cmd_o.ratio_init = 1'b1;
      ST_RLOAD:  cmd_o.load_div_ratio = 1'b1;
      ST_RDIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.quo_en   = 1'b1;
      end
      ST_RWRITE: begin
        cmd_o.mem_we     = 1'b1;
        cmd_o.ratio_next = 1'b1;
      end
      ST_IDLE:   cmd_o.load_x = in_valid_i;
      ST_SQUARE: cmd_o.square = 1'b1;
      ST_DLOAD:  cmd_o.load_div_main = 1'b1;
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.quo_en   = cnt_q < 7'(FRAC_BITS);
        cmd_o.pair_hi  = !cnt_q[0];
        cmd_o.pair_lo  = cnt_q[0];
      end
      ST_DRAIN: ;
      ST_S0: begin
        cmd_o.mem_re  = 1'b1;
        cmd_o.mul_lo  = 1'b1;
        cmd_o.sum_add = k_q != CNT_W'(1);
      end
      ST_S1: cmd_o.mul_hi = 1'b1;
      ST_S2: begin
        cmd_o.mul_lo = 1'b1;
        cmd_o.mul_b  = MB_RATIO;
      end
      ST_S3: begin
        cmd_o.mul_hi = 1'b1;
        cmd_o.mul_b  = MB_RATIO;
      end
      ST_SACC: cmd_o.sum_add = 1'b1;
      ST_F0: begin
        cmd_o.mul_lo    = 1'b1;
        cmd_o.mul_a_sum = 1'b1;
        cmd_o.mul_b     = MB_ROOT;
      end
      ST_F1: begin
        cmd_o.mul_hi     = 1'b1;
        cmd_o.mul_a_sum  = 1'b1;
        cmd_o.mul_b      = MB_ROOT;
        cmd_o.mul_to_res = 1'b1;
      end
      ST_OUT:  cmd_o.out_load = slot_free;
      default: ;
    endcase
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_vld_q;

endmodule

@@ src/arctan_series_evaluator.sv @@
// arctan(x) through the arcsin series of x / sqrt(1 + x^2)
//
// input stream: s_axis_tdata carries x as signed Q16.16; one item is taken
// when tvalid and tready are both high. tready is high only while the block
// is idle, so one item is in work at a time.
// output stream: m_axis_tdata carries arctan(x) as signed Q2.30, saturated
// to +/- pi/2, held in an output register until taken; a stalled receiver
// holds the finished item and the next item is still accepted, but its
// result waits until the register frees.
// cfg_we_i / cfg_wdata_i write the term count (reset 1000, capped at 1024);
// write only while idle.
// each item runs a 76-step restoring divide feeding a square root, then
// two passes through a shared 40 x 20 multiplier for each of the two
// products of every term. after reset the ratio table of 1024 entries is
// built by the same divider, with tready low; a new reset rebuilds it.
module arctan_series_evaluator import ase_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // [31:0] x_value
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [31:0] angle
);

  cmd_t cmd;

  ase_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  ase_datapath u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .x_i     (s_axis_tdata),
    .angle_o (m_axis_tdata)
  );

endmodule
